// ===== hw/rtl/qpsa_pkg.sv =====
// ----------------------------------------------------------------------------
// Quaternion product square accumulate package
// Queue sizing, the output width and the status type shared by the front, the queue, the back and the top.
// ----------------------------------------------------------------------------
package qpsa_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_WIDTH   = 64;

    typedef struct packed {
        logic              empty;
        logic [QCNT_W-1:0] count;
    } t_q_stat;

endpackage

// ===== hw/rtl/qpsa_front.sv =====
// ----------------------------------------------------------------------------
// Quaternion product square accumulate front
// Accepts input words and forms the Hamilton product in three stages.
// ----------------------------------------------------------------------------
module qpsa_front import qpsa_pkg::*; #(
    parameter int CW = 12,
    parameter int PW = 26
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [CW-1:0] i_a_real,
    input  logic signed [CW-1:0] i_a_i,
    input  logic signed [CW-1:0] i_a_j,
    input  logic signed [CW-1:0] i_a_k,
    input  logic signed [CW-1:0] i_b_real,
    input  logic signed [CW-1:0] i_b_i,
    input  logic signed [CW-1:0] i_b_j,
    input  logic signed [CW-1:0] i_b_k,
    input  logic                 i_last_pair,
    input  t_q_stat              i_qstat,
    output logic                 o_push,
    output logic [4*PW:0]        o_push_data
);

    localparam int MW = 2 * CW;

    logic signed [CW-1:0] r_a [4];
    logic signed [CW-1:0] r_b [4];
    logic signed [MW-1:0] r_p [16];
    logic signed [PW-1:0] r_w, r_x, r_y, r_z;
    logic                 r_v1, r_v2, r_v3;
    logic                 r_last1, r_last2, r_last3;
    logic [QCNT_W:0]      w_used;
    logic                 w_accept;

    // Credit check: the queue must hold every word already in the pipeline.
    assign w_used = {1'b0, i_qstat.count} + (QCNT_W + 1)'(r_v1)
                  + (QCNT_W + 1)'(r_v2) + (QCNT_W + 1)'(r_v3);
    assign o_stall  = (w_used >= (QCNT_W + 1)'(QUEUE_DEPTH));
    assign w_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= w_accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a[0]  <= i_a_real;
            r_a[1]  <= i_a_i;
            r_a[2]  <= i_a_j;
            r_a[3]  <= i_a_k;
            r_b[0]  <= i_b_real;
            r_b[1]  <= i_b_i;
            r_b[2]  <= i_b_j;
            r_b[3]  <= i_b_k;
            r_last1 <= i_last_pair;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                r_p[4*i+j] <= MW'(r_a[i]) * MW'(r_b[j]);
            end
        end
        r_last2 <= r_last1;
    end

    always_ff @(posedge i_clk) begin
        r_w <= PW'(r_p[0])  - PW'(r_p[5])  - PW'(r_p[10]) - PW'(r_p[15]);
        r_x <= PW'(r_p[1])  + PW'(r_p[4])  + PW'(r_p[11]) - PW'(r_p[14]);
        r_y <= PW'(r_p[2])  - PW'(r_p[7])  + PW'(r_p[8])  + PW'(r_p[13]);
        r_z <= PW'(r_p[3])  + PW'(r_p[6])  - PW'(r_p[9])  + PW'(r_p[12]);
        r_last3 <= r_last2;
    end

    assign o_push      = r_v3;
    assign o_push_data = {r_last3, r_w, r_x, r_y, r_z};

endmodule

// ===== hw/rtl/qpsa_queue.sv =====
// ----------------------------------------------------------------------------
// Quaternion product square accumulate queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module qpsa_queue import qpsa_pkg::*; #(
    parameter int DW = 105
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_push_data,
    input  logic          i_pop,
    output logic [DW-1:0] o_pop_data,
    output t_q_stat       o_qstat
);

    logic [DW-1:0]     r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_pop_data    = r_mem[r_rd_ptr];
    assign o_qstat.count = r_count;
    assign o_qstat.empty = (r_count == '0);

endmodule

// ===== hw/rtl/qpsa_back.sv =====
// ----------------------------------------------------------------------------
// Quaternion product square accumulate back
// Squares each product, adds it into saturating sums and holds the result word.
// ----------------------------------------------------------------------------
module qpsa_back import qpsa_pkg::*; #(
    parameter int PW = 26,
    parameter int AW = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [4*PW:0]        i_pop_data,
    input  t_q_stat              i_qstat,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [OUT_WIDTH-1:0] o_sum_real,
    output logic [OUT_WIDTH-1:0] o_sum_i,
    output logic [OUT_WIDTH-1:0] o_sum_j,
    output logic [OUT_WIDTH-1:0] o_sum_k
);

    localparam int MW = 2 * PW;
    localparam int SW = MW + 1;
    localparam int EW = ((SW > AW) ? SW : AW) + 1;

    function automatic logic signed [AW-1:0] f_sat_add(
        input logic signed [AW-1:0] acc,
        input logic signed [SW-1:0] d
    );
        logic signed [EW-1:0] s;
        logic [EW-AW:0]       top;
        s   = EW'(acc) + EW'(d);
        top = s[EW-1:AW-1];
        if ((&top) || !(|top)) begin
            f_sat_add = s[AW-1:0];
        end else if (s[EW-1]) begin
            f_sat_add = {1'b1, {(AW-1){1'b0}}};
        end else begin
            f_sat_add = {1'b0, {(AW-1){1'b1}}};
        end
    endfunction

    logic signed [PW-1:0] r_w, r_x, r_y, r_z;
    logic signed [MW-1:0] r_ww, r_xx, r_yy, r_zz, r_wx, r_wy, r_wz;
    logic signed [SW-1:0] r_sq_r, r_sq_i, r_sq_j, r_sq_k;
    logic signed [AW-1:0] r_acc_r, r_acc_i, r_acc_j, r_acc_k;
    logic signed [AW-1:0] n_acc_r, n_acc_i, n_acc_j, n_acc_k;
    logic                 r_v1, r_v2, r_v3;
    logic                 r_last1, r_last2, r_last3;
    logic                 r_out_v;
    logic                 w_en;
    logic                 w_fin;

    // The pipeline holds only when a finished sum meets a result word still waiting.
    assign w_en  = !(r_out_v && i_stall && r_v3 && r_last3);
    assign o_pop = w_en && !i_qstat.empty;
    assign w_fin = w_en && r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= o_pop;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_last1 <= i_pop_data[4*PW];
            r_w     <= i_pop_data[4*PW-1:3*PW];
            r_x     <= i_pop_data[3*PW-1:2*PW];
            r_y     <= i_pop_data[2*PW-1:PW];
            r_z     <= i_pop_data[PW-1:0];
            r_last2 <= r_last1;
            r_ww    <= MW'(r_w) * MW'(r_w);
            r_xx    <= MW'(r_x) * MW'(r_x);
            r_yy    <= MW'(r_y) * MW'(r_y);
            r_zz    <= MW'(r_z) * MW'(r_z);
            r_wx    <= MW'(r_w) * MW'(r_x);
            r_wy    <= MW'(r_w) * MW'(r_y);
            r_wz    <= MW'(r_w) * MW'(r_z);
            r_last3 <= r_last2;
            r_sq_r  <= SW'(r_ww) - SW'(r_xx) - SW'(r_yy) - SW'(r_zz);
            r_sq_i  <= {r_wx, 1'b0};
            r_sq_j  <= {r_wy, 1'b0};
            r_sq_k  <= {r_wz, 1'b0};
        end
    end

    always_comb begin
        n_acc_r = f_sat_add(r_acc_r, r_sq_r);
        n_acc_i = f_sat_add(r_acc_i, r_sq_i);
        n_acc_j = f_sat_add(r_acc_j, r_sq_j);
        n_acc_k = f_sat_add(r_acc_k, r_sq_k);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_r <= '0;
            r_acc_i <= '0;
            r_acc_j <= '0;
            r_acc_k <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (w_fin && r_last3) begin
                r_acc_r <= '0;
                r_acc_i <= '0;
                r_acc_j <= '0;
                r_acc_k <= '0;
                r_out_v <= 1'b1;
            end else begin
                if (w_fin) begin
                    r_acc_r <= n_acc_r;
                    r_acc_i <= n_acc_i;
                    r_acc_j <= n_acc_j;
                    r_acc_k <= n_acc_k;
                end
                if (r_out_v && !i_stall) begin
                    r_out_v <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin && r_last3) begin
            o_sum_real <= OUT_WIDTH'(n_acc_r);
            o_sum_i    <= OUT_WIDTH'(n_acc_i);
            o_sum_j    <= OUT_WIDTH'(n_acc_j);
            o_sum_k    <= OUT_WIDTH'(n_acc_k);
        end
    end

    assign o_valid = r_out_v;

endmodule

// ===== hw/rtl/quaternion_product_square_accumulate.sv =====
// ----------------------------------------------------------------------------
// Quaternion product square accumulate
// Takes one pair of quaternions per word, squares their Hamilton product and
// sums the squares into four saturating accumulators. A word flagged last
// pair closes the set: its square is added, the four sums go out as one
// result word and the accumulators return to zero. The block sustains one
// word per cycle while o_stall is low. A word passes through the product
// pipeline of the front, the eight-entry queue and the square and accumulate
// pipeline of the back, and the result word is registered once its last
// pair leaves the back pipeline. The front stops taking words when the queue
// cannot hold all words in flight; the back holds only while a result word
// waits to be taken and another finished set is ready behind it.
// ----------------------------------------------------------------------------
module quaternion_product_square_accumulate import qpsa_pkg::*; #(
    parameter int COMPONENT_WIDTH = 12,
    parameter int ACC_WIDTH       = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [COMPONENT_WIDTH-1:0] i_a_real,
    input  logic signed [COMPONENT_WIDTH-1:0] i_a_i,
    input  logic signed [COMPONENT_WIDTH-1:0] i_a_j,
    input  logic signed [COMPONENT_WIDTH-1:0] i_a_k,
    input  logic signed [COMPONENT_WIDTH-1:0] i_b_real,
    input  logic signed [COMPONENT_WIDTH-1:0] i_b_i,
    input  logic signed [COMPONENT_WIDTH-1:0] i_b_j,
    input  logic signed [COMPONENT_WIDTH-1:0] i_b_k,
    input  logic                              i_last_pair,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [OUT_WIDTH-1:0]       o_sum_real,
    output logic signed [OUT_WIDTH-1:0]       o_sum_i,
    output logic signed [OUT_WIDTH-1:0]       o_sum_j,
    output logic signed [OUT_WIDTH-1:0]       o_sum_k
);

    localparam int PW = 2 * COMPONENT_WIDTH + 2;
    localparam int DW = 4 * PW + 1;

    logic          w_push;
    logic [DW-1:0] w_push_data;
    logic          w_pop;
    logic [DW-1:0] w_pop_data;
    t_q_stat       w_qstat;

    qpsa_front #(
        .CW (COMPONENT_WIDTH),
        .PW (PW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_a_real    (i_a_real),
        .i_a_i       (i_a_i),
        .i_a_j       (i_a_j),
        .i_a_k       (i_a_k),
        .i_b_real    (i_b_real),
        .i_b_i       (i_b_i),
        .i_b_j       (i_b_j),
        .i_b_k       (i_b_k),
        .i_last_pair (i_last_pair),
        .i_qstat     (w_qstat),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    qpsa_queue #(
        .DW (DW)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_data),
        .o_qstat     (w_qstat)
    );

    qpsa_back #(
        .PW (PW),
        .AW (ACC_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pop_data (w_pop_data),
        .i_qstat    (w_qstat),
        .o_pop      (w_pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_sum_real (o_sum_real),
        .o_sum_i    (o_sum_i),
        .o_sum_j    (o_sum_j),
        .o_sum_k    (o_sum_k)
    );

`ifndef NO_ASSERTIONS
    a_no_push_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (w_qstat.count != QCNT_W'(QUEUE_DEPTH)))
        else $error("queue written while full");

    a_no_pop_when_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_qstat.empty)
        else $error("queue read while empty");

    a_count_tracks : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (w_qstat.count == $past(w_qstat.count) + 1'b1))
        else $error("queue count lost a written word");
`endif

endmodule

// ===== tb/qpsa_sums_checker.sv =====
// ----------------------------------------------------------------------------
// Quaternion product square accumulate checker
// Watches both channels of the block. Each pair word taken is run through a
// copy of the product, square and saturating accumulate, and each closed set
// leaves its four sums in a queue. Every result word is compared with the
// oldest queued sums. The number of mismatches and of sums still due go to
// the testbench top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qpsa_sums_checker import qpsa_pkg::*; #(
    parameter int COMPONENT_WIDTH = 12,
    parameter int ACC_WIDTH       = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  logic signed [COMPONENT_WIDTH-1:0] i_a_real,
    input  logic signed [COMPONENT_WIDTH-1:0] i_a_i,
    input  logic signed [COMPONENT_WIDTH-1:0] i_a_j,
    input  logic signed [COMPONENT_WIDTH-1:0] i_a_k,
    input  logic signed [COMPONENT_WIDTH-1:0] i_b_real,
    input  logic signed [COMPONENT_WIDTH-1:0] i_b_i,
    input  logic signed [COMPONENT_WIDTH-1:0] i_b_j,
    input  logic signed [COMPONENT_WIDTH-1:0] i_b_k,
    input  logic                              i_last_pair,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic signed [OUT_WIDTH-1:0]       i_sum_real,
    input  logic signed [OUT_WIDTH-1:0]       i_sum_i,
    input  logic signed [OUT_WIDTH-1:0]       i_sum_j,
    input  logic signed [OUT_WIDTH-1:0]       i_sum_k,
    output int                                o_mismatches,
    output int                                o_sums_due
);

    typedef logic signed [ACC_WIDTH-1:0] t_acc;
    typedef logic signed [OUT_WIDTH-1:0] t_sum;

    typedef struct {
        t_sum re;
        t_sum vi;
        t_sum vj;
        t_sum vk;
    } t_sums;

    t_acc  acc_re;
    t_acc  acc_vi;
    t_acc  acc_vj;
    t_acc  acc_vk;
    t_sums sums_due[$];

    function automatic t_acc sat_accumulate(t_acc acc, longint delta);
        logic signed [65:0] wide;
        logic signed [65:0] ceiling;
        logic signed [65:0] floor_val;
        ceiling   = (66'sd1 <<< (ACC_WIDTH - 1)) - 66'sd1;
        floor_val = -(66'sd1 <<< (ACC_WIDTH - 1));
        wide      = acc;
        wide      = wide + delta;
        if (wide > ceiling) begin
            wide = ceiling;
        end else if (wide < floor_val) begin
            wide = floor_val;
        end
        return wide[ACC_WIDTH-1:0];
    endfunction

    task automatic compare_field(string name, t_sum want, t_sum got);
        if (got !== want) begin
            $error("%s expected %0d got %0d", name, want, got);
            o_mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        longint a0, a1, a2, a3, b0, b1, b2, b3;
        longint w, x, y, z;
        t_sums  sums;
        if (!i_rst_n) begin
            acc_re = '0;
            acc_vi = '0;
            acc_vj = '0;
            acc_vk = '0;
            sums_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (sums_due.size() == 0) begin
                    $error("result word with no sums due: %0d %0d %0d %0d",
                           i_sum_real, i_sum_i, i_sum_j, i_sum_k);
                    o_mismatches++;
                end else begin
                    sums = sums_due.pop_front();
                    compare_field("sum_real", sums.re, i_sum_real);
                    compare_field("sum_i", sums.vi, i_sum_i);
                    compare_field("sum_j", sums.vj, i_sum_j);
                    compare_field("sum_k", sums.vk, i_sum_k);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                a0 = i_a_real;
                a1 = i_a_i;
                a2 = i_a_j;
                a3 = i_a_k;
                b0 = i_b_real;
                b1 = i_b_i;
                b2 = i_b_j;
                b3 = i_b_k;
                w = a0 * b0 - a1 * b1 - a2 * b2 - a3 * b3;
                x = a0 * b1 + a1 * b0 + a2 * b3 - a3 * b2;
                y = a0 * b2 - a1 * b3 + a2 * b0 + a3 * b1;
                z = a0 * b3 + a1 * b2 - a2 * b1 + a3 * b0;
                acc_re = sat_accumulate(acc_re, w * w - x * x - y * y - z * z);
                acc_vi = sat_accumulate(acc_vi, 2 * w * x);
                acc_vj = sat_accumulate(acc_vj, 2 * w * y);
                acc_vk = sat_accumulate(acc_vk, 2 * w * z);
                if (i_last_pair) begin
                    sums.re = acc_re;
                    sums.vi = acc_vi;
                    sums.vj = acc_vj;
                    sums.vk = acc_vk;
                    sums_due.push_back(sums);
                    acc_re = '0;
                    acc_vi = '0;
                    acc_vj = '0;
                    acc_vk = '0;
                end
            end
        end
        o_sums_due = sums_due.size();
    end

endmodule

// ===== tb/quaternion_product_square_accumulate_tb.sv =====
// ----------------------------------------------------------------------------
// Quaternion product square accumulate testbench
// Drives pair words into the block and takes its result words, both sides
// idling in random bursts. A short directed part covers the component
// extremes, the basis products and single-pair sets; long sets of extreme
// pairs then build large sums, and random sets of random length finish the
// run. The checker beside the block predicts and compares; this module gives
// the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quaternion_product_square_accumulate_tb;
    import qpsa_pkg::*;

    localparam int CW           = 12;
    localparam int AW           = 64;
    localparam int RANDOM_PAIRS = 1000;

    typedef logic signed [CW-1:0] t_comp;

    localparam t_comp CMIN = {1'b1, {(CW - 1){1'b0}}};
    localparam t_comp CMAX = {1'b0, {(CW - 1){1'b1}}};

    typedef struct packed {
        t_comp ar;
        t_comp ai;
        t_comp aj;
        t_comp ak;
        t_comp br;
        t_comp bi;
        t_comp bj;
        t_comp bk;
        logic  last;
    } t_pair;

    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        i_valid     = 1'b0;
    logic                        i_stall     = 1'b0;
    t_comp                       i_a_real    = '0;
    t_comp                       i_a_i       = '0;
    t_comp                       i_a_j       = '0;
    t_comp                       i_a_k       = '0;
    t_comp                       i_b_real    = '0;
    t_comp                       i_b_i       = '0;
    t_comp                       i_b_j       = '0;
    t_comp                       i_b_k       = '0;
    logic                        i_last_pair = 1'b0;
    logic                        o_stall;
    logic                        o_valid;
    logic signed [OUT_WIDTH-1:0] o_sum_real;
    logic signed [OUT_WIDTH-1:0] o_sum_i;
    logic signed [OUT_WIDTH-1:0] o_sum_j;
    logic signed [OUT_WIDTH-1:0] o_sum_k;

    int mismatches;
    int sums_due;
    int idle_odds = 0;
    int stall_left;

    always #2 i_clk = ~i_clk;

    quaternion_product_square_accumulate #(
        .COMPONENT_WIDTH (CW),
        .ACC_WIDTH       (AW)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_a_real    (i_a_real),
        .i_a_i       (i_a_i),
        .i_a_j       (i_a_j),
        .i_a_k       (i_a_k),
        .i_b_real    (i_b_real),
        .i_b_i       (i_b_i),
        .i_b_j       (i_b_j),
        .i_b_k       (i_b_k),
        .i_last_pair (i_last_pair),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_sum_real  (o_sum_real),
        .o_sum_i     (o_sum_i),
        .o_sum_j     (o_sum_j),
        .o_sum_k     (o_sum_k)
    );

    qpsa_sums_checker #(
        .COMPONENT_WIDTH (CW),
        .ACC_WIDTH       (AW)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_a_real     (i_a_real),
        .i_a_i        (i_a_i),
        .i_a_j        (i_a_j),
        .i_a_k        (i_a_k),
        .i_b_real     (i_b_real),
        .i_b_i        (i_b_i),
        .i_b_j        (i_b_j),
        .i_b_k        (i_b_k),
        .i_last_pair  (i_last_pair),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_sum_real   (o_sum_real),
        .i_sum_i      (o_sum_i),
        .i_sum_j      (o_sum_j),
        .i_sum_k      (o_sum_k),
        .o_mismatches (mismatches),
        .o_sums_due   (sums_due)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            i_stall    <= 1'b1;
            stall_left <= $urandom_range(0, 8);
        end else begin
            i_stall <= 1'b0;
        end
    end

    function automatic t_pair make_pair(t_comp ar, t_comp ai, t_comp aj, t_comp ak,
                                        t_comp br, t_comp bi, t_comp bj, t_comp bk,
                                        logic last);
        return '{ar, ai, aj, ak, br, bi, bj, bk, last};
    endfunction

    function automatic t_comp rand_comp();
        case ($urandom_range(0, 7))
            0: begin
                return CMIN;
            end
            1: begin
                return CMAX;
            end
            2: begin
                return '0;
            end
            3: begin
                return t_comp'($urandom_range(0, 6) - 3);
            end
            default: begin
                return t_comp'($urandom());
            end
        endcase
    endfunction

    task automatic send_pair(t_pair p);
        int gap;
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            gap = $urandom_range(1, 9);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_a_real    <= p.ar;
        i_a_i       <= p.ai;
        i_a_j       <= p.aj;
        i_a_k       <= p.ak;
        i_b_real    <= p.br;
        i_b_i       <= p.bi;
        i_b_j       <= p.bj;
        i_b_k       <= p.bk;
        i_last_pair <= p.last;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic send_set(t_pair p, int pairs);
        for (int n = 0; n < pairs; n++) begin
            p.last = (n == pairs - 1);
            send_pair(p);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (sums_due == 0);
    endtask

    initial begin
        int    sent;
        int    set_len;
        bit    paused;
        t_comp c[8];
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_odds = 4;
        send_pair(make_pair('0, '0, '0, '0, '0, '0, '0, '0, 1'b1));
        send_pair(make_pair(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 1'b1));
        send_pair(make_pair(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 1'b1));
        send_pair(make_pair(CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, 1'b1));
        send_pair(make_pair(CMIN, CMAX, CMIN, CMAX, CMAX, CMIN, CMAX, CMIN, 1'b1));
        send_pair(make_pair(1, 0, 0, 0, 0, 1, 0, 0, 1'b0));
        send_pair(make_pair(0, 1, 0, 0, 0, 0, 1, 0, 1'b0));
        send_pair(make_pair(0, 0, 1, 0, 0, 0, 0, 1, 1'b0));
        send_pair(make_pair(0, 0, 0, 1, 0, 1, 0, 0, 1'b1));
        send_pair(make_pair(12'sh555, 12'shaaa, 12'sh555, 12'shaaa,
                            12'shaaa, 12'sh555, 12'shaaa, 12'sh555, 1'b1));
        send_pair(make_pair(5, -7, 3, -2, -1, 4, -6, 8, 1'b0));
        send_pair(make_pair(-5, 7, -3, 2, 1, -4, 6, -8, 1'b0));
        send_pair(make_pair(CMAX, 0, CMIN, 0, 0, CMAX, 0, CMIN, 1'b1));
        wait_drained();

        // Long sets of extreme pairs build large sums.
        idle_odds = 32;
        send_set(make_pair(CMIN, CMAX, CMIN, CMIN, CMIN, CMIN, CMAX, CMIN, 1'b0), 100);
        send_set(make_pair(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 1'b0), 100);
        send_set(make_pair(CMIN, CMIN, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 1'b0), 100);

        sent   = 0;
        paused = 1'b0;
        while (sent < RANDOM_PAIRS) begin
            set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                  : $urandom_range(1, 8);
            if (sent >= RANDOM_PAIRS - 150) begin
                idle_odds = 0;
            end else begin
                case ($urandom_range(0, 3))
                    0: begin
                        idle_odds = 0;
                    end
                    1: begin
                        idle_odds = 2;
                    end
                    default: begin
                        idle_odds = 5;
                    end
                endcase
            end
            for (int n = 0; n < set_len; n++) begin
                foreach (c[m]) c[m] = rand_comp();
                send_pair(make_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7],
                                    n == set_len - 1));
                sent++;
            end
            if (!paused && sent >= RANDOM_PAIRS / 2) begin
                paused = 1'b1;
                wait_drained();
            end
        end

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #80ms;
        $display("status: fail");
        $finish;
    end

endmodule
